// ===== sv/lzbd_pkg.sv =====
`default_nettype none
package lzbd_pkg;

    localparam int HIST_DEPTH = 65536;
    localparam int HIST_AW = $clog2(HIST_DEPTH);

    localparam int LIMIT_W = 17;
    localparam int COUNT_W = 20;
    localparam int REM_W = 11;
    localparam int POS_W = 16;

    localparam logic [LIMIT_W-1:0] DEPTH_LIMIT = LIMIT_W'(HIST_DEPTH);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;

    localparam logic [1:0] MODE_FEED = 2'd0;
    localparam logic [1:0] MODE_DRAW = 2'd1;
    localparam logic [1:0] MODE_END = 2'd2;

    localparam logic [2:0] CMD_LITERAL = 3'd0;
    localparam logic [2:0] CMD_RUN = 3'd1;
    localparam logic [2:0] CMD_PAIR = 3'd2;
    localparam logic [2:0] CMD_INCR = 3'd3;
    localparam logic [2:0] CMD_COPY = 3'd4;
    localparam logic [2:0] CMD_REVCOPY = 3'd5;
    localparam logic [2:0] CMD_BACKCOPY = 3'd6;
    localparam logic [2:0] CMD_EXTENDED = 3'd7;

    localparam logic [7:0] HDR_END = 8'hFF;
    localparam logic [7:0] EXT_CMD_MASK = 8'h1C;
    localparam logic [7:0] LEN_MASK = 8'h1F;

    localparam logic [2:0] ST_RUNNING = 3'd0;
    localparam logic [2:0] ERR_LENGTH = 3'd1;
    localparam logic [2:0] ERR_POSITION = 3'd2;
    localparam logic [2:0] ERR_COPY = 3'd3;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd4;
    localparam logic [2:0] ERR_RESERVED = 3'd5;
    localparam logic [2:0] ERR_TRUNCATED = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    // One accepted word as it leaves the parser for the history stage.
    typedef struct packed {
        logic                 emit;
        logic                 hist;
        logic                 rev;
        logic                 rd_ok;
        logic [HIST_AW-1:0]   rd_addr;
        logic                 wr_en;
        logic [HIST_AW-1:0]   wr_addr;
        logic [7:0]           lit;
        logic                 need_input;
        logic                 done_res;
        logic [2:0]           error_code;
        logic [COUNT_W-1:0]   consumed_count;
        logic [LIMIT_W-1:0]   out_length;
    } step_t;

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/lzbd_ctrl.sv =====
`default_nettype none
module lzbd_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [lzbd_pkg::LIMIT_W-1:0] cfg_data,
    input  wire logic                       accept,
    input  wire logic [1:0]                 mode,
    input  wire logic [7:0]                 in_byte,
    output lzbd_pkg::step_t                 step
);
    import lzbd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER, PH_EXTLEN, PH_POSHI, PH_POSLO, PH_FILL, PH_EMIT, PH_FINISHED
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [LIMIT_W-1:0]   wp_reg, wp_next;
    logic [POS_W-1:0]     src_reg, src_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [2:0]           cmd_reg, cmd_next;
    logic                 tog_reg, tog_next;
    logic [7:0]           f1_reg, f1_next;
    logic [7:0]           f2_reg, f2_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [2:0]           status_reg, status_next;
    logic [LIMIT_W-1:0]   limit_cfg_reg;

    logic [LIMIT_W-1:0]   limit;
    logic                 do_start;
    logic [2:0]           s_cmd;
    logic [REM_W-1:0]     s_len;
    logic [1:0]           add_n;
    logic [COUNT_W:0]     cnt_sum;
    logic [COUNT_W:0]     cnt_out;
    logic [LIMIT_W:0]     need_end;
    logic [LIMIT_W:0]     pos_end;
    logic [POS_W-1:0]     pos;
    logic [REM_W-1:0]     ext_len;

    assign limit = (limit_cfg_reg > DEPTH_LIMIT) ? DEPTH_LIMIT : limit_cfg_reg;

    always_comb
    begin
        phase_next = phase_reg;
        wp_next = wp_reg;
        src_next = src_reg;
        rem_next = rem_reg;
        cmd_next = cmd_reg;
        tog_next = tog_reg;
        f1_next = f1_reg;
        f2_next = f2_reg;
        status_next = status_reg;
        do_start = 1'b0;
        s_cmd = in_byte[7:5];
        s_len = REM_W'(in_byte[4:0]) + 1'b1;
        add_n = 2'd0;
        pos = {src_reg[POS_W-1:8], in_byte};
        ext_len = rem_reg + REM_W'(in_byte) + 1'b1;
        need_end = '0;
        pos_end = '0;
        step = '0;

        if (accept && phase_reg != PH_FINISHED)
        begin
            if (mode == MODE_FEED && phase_reg != PH_EMIT)
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (in_byte == HDR_END)
                        begin
                            status_next = ST_DONE;
                            phase_next = PH_FINISHED;
                        end
                        else if (in_byte[7:5] == CMD_EXTENDED)
                        begin
                            cmd_next = 3'((in_byte & EXT_CMD_MASK) >> 2);
                            rem_next = {1'b0, in_byte[1:0], 8'h00};
                            add_n = 2'd1;
                            phase_next = PH_EXTLEN;
                        end
                        else
                        begin
                            s_len = REM_W'(in_byte & LEN_MASK) + 1'b1;
                            need_end = {1'b0, wp_reg} + (LIMIT_W+1)'(s_len);
                            if (need_end > {1'b0, limit})
                            begin
                                status_next = ERR_LENGTH;
                                phase_next = PH_FINISHED;
                            end
                            else
                            begin
                                add_n = 2'd1;
                                do_start = 1'b1;
                            end
                        end
                    end
                    PH_EXTLEN:
                    begin
                        s_cmd = cmd_reg;
                        s_len = ext_len;
                        need_end = {1'b0, wp_reg} + (LIMIT_W+1)'(ext_len);
                        if (need_end > {1'b0, limit})
                        begin
                            status_next = ERR_LENGTH;
                            phase_next = PH_FINISHED;
                        end
                        else
                        begin
                            add_n = 2'd1;
                            do_start = 1'b1;
                        end
                    end
                    PH_POSHI:
                    begin
                        src_next = {in_byte, 8'h00};
                        phase_next = PH_POSLO;
                    end
                    PH_POSLO:
                    begin
                        pos_end = (LIMIT_W+1)'(pos) + (LIMIT_W+1)'(rem_reg);
                        if ({1'b0, pos} >= limit)
                        begin
                            status_next = ERR_POSITION;
                            phase_next = PH_FINISHED;
                        end
                        else
                        begin
                            add_n = 2'd2;
                            src_next = pos;
                            if ((cmd_reg == CMD_COPY || cmd_reg == CMD_REVCOPY) &&
                                pos_end > {1'b0, limit})
                            begin
                                status_next = ERR_COPY;
                                phase_next = PH_FINISHED;
                            end
                            else if (cmd_reg == CMD_BACKCOPY &&
                                     (POS_W+1)'(pos) + 1'b1 < (POS_W+1)'(rem_reg))
                            begin
                                status_next = ERR_UNDERFLOW;
                                phase_next = PH_FINISHED;
                            end
                            else if (cmd_reg == CMD_EXTENDED)
                            begin
                                status_next = ERR_RESERVED;
                                phase_next = PH_FINISHED;
                            end
                            else
                            begin
                                phase_next = PH_EMIT;
                            end
                        end
                    end
                    PH_FILL:
                    begin
                        if (cmd_reg == CMD_PAIR)
                        begin
                            if (!tog_reg)
                            begin
                                f1_next = in_byte;
                                tog_next = 1'b1;
                            end
                            else
                            begin
                                f2_next = in_byte;
                                tog_next = 1'b0;
                                add_n = 2'd2;
                                phase_next = PH_EMIT;
                            end
                        end
                        else
                        begin
                            f1_next = in_byte;
                            add_n = 2'd1;
                            phase_next = PH_EMIT;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (do_start)
                begin
                    cmd_next = s_cmd;
                    rem_next = s_len;
                    tog_next = 1'b0;
                    need_end = {1'b0, wp_reg} + (LIMIT_W+1)'({s_len, 1'b0});
                    if (s_cmd == CMD_PAIR && need_end > {1'b0, limit})
                    begin
                        status_next = ERR_LENGTH;
                        phase_next = PH_FINISHED;
                    end
                    else if (s_cmd >= CMD_COPY)
                    begin
                        phase_next = PH_POSHI;
                    end
                    else
                    begin
                        phase_next = PH_FILL;
                    end
                end
            end
            else if (mode == MODE_DRAW && phase_reg == PH_EMIT)
            begin
                step.emit = 1'b1;
                step.wr_en = wp_reg < DEPTH_LIMIT;
                step.wr_addr = wp_reg[HIST_AW-1:0];
                step.rd_addr = src_reg[HIST_AW-1:0];
                // Entries at or beyond the write pointer were never written since reset.
                step.rd_ok = ({1'b0, src_reg} < wp_reg) && ({1'b0, src_reg} < DEPTH_LIMIT);
                rem_next = rem_reg - 1'b1;
                unique case (cmd_reg)
                    CMD_LITERAL, CMD_RUN:
                    begin
                        step.lit = f1_reg;
                    end
                    CMD_PAIR:
                    begin
                        step.lit = tog_reg ? f2_reg : f1_reg;
                        rem_next = tog_reg ? rem_reg - 1'b1 : rem_reg;
                        tog_next = ~tog_reg;
                    end
                    CMD_INCR:
                    begin
                        step.lit = f1_reg;
                        f1_next = f1_reg + 1'b1;
                    end
                    CMD_COPY, CMD_REVCOPY:
                    begin
                        step.hist = 1'b1;
                        step.rev = (cmd_reg == CMD_REVCOPY);
                        src_next = src_reg + 1'b1;
                    end
                    CMD_BACKCOPY:
                    begin
                        step.hist = 1'b1;
                        src_next = src_reg - 1'b1;
                    end
                    default:
                    begin
                        rem_next = '0;
                    end
                endcase
                wp_next = wp_reg + 1'b1;
                if (rem_next == '0)
                begin
                    phase_next = PH_HEADER;
                end
                else if (cmd_reg == CMD_LITERAL)
                begin
                    phase_next = PH_FILL;
                end
            end
            else if (mode == MODE_END && phase_reg != PH_EMIT)
            begin
                phase_next = PH_FINISHED;
                if (phase_reg == PH_HEADER || (phase_reg == PH_FILL && cmd_reg == CMD_LITERAL))
                begin
                    status_next = ST_DONE;
                end
                else
                begin
                    status_next = ERR_TRUNCATED;
                end
            end
        end

        cnt_sum = {1'b0, cnt_reg} + (COUNT_W+1)'(add_n);
        cnt_next = (cnt_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : cnt_sum[COUNT_W-1:0];
        cnt_out = {1'b0, cnt_next} + 1'b1;

        step.need_input = (phase_next != PH_EMIT) && (phase_next != PH_FINISHED);
        step.done_res = (status_next == ST_DONE);
        step.error_code = (status_next == ST_DONE) ? ST_RUNNING : status_next;
        step.consumed_count = (cnt_out > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                           : cnt_out[COUNT_W-1:0];
        step.out_length = wp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            wp_reg <= '0;
            src_reg <= '0;
            rem_reg <= '0;
            cmd_reg <= CMD_LITERAL;
            tog_reg <= 1'b0;
            f1_reg <= '0;
            f2_reg <= '0;
            cnt_reg <= '0;
            status_reg <= ST_RUNNING;
            limit_cfg_reg <= LIMIT_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            wp_reg <= wp_next;
            src_reg <= src_next;
            rem_reg <= rem_next;
            cmd_reg <= cmd_next;
            tog_reg <= tog_next;
            f1_reg <= f1_next;
            f2_reg <= f2_next;
            cnt_reg <= cnt_next;
            status_reg <= status_next;
            if (cfg_we)
            begin
                limit_cfg_reg <= cfg_data;
            end
        end
    end

    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FINISHED |=> phase_reg == PH_FINISHED && $stable(status_reg))
        else $error("finished decoder left its final state");
    a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg != ST_RUNNING) == (phase_reg == PH_FINISHED))
        else $error("status and phase disagree");
    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step.emit |-> wp_reg < limit)
        else $error("emit past output limit");
endmodule
`default_nettype wire

// ===== sv/lzbd_hist.sv =====
`default_nettype none
module lzbd_hist (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  lzbd_pkg::step_t      step,
    output logic                 busy,
    input  wire logic            m_tready,
    output logic                 m_tvalid,
    output logic [55:0]          m_tdata,
    output logic [0:0]           m_tuser
);
    import lzbd_pkg::*;

    logic [7:0]   mem [HIST_DEPTH];
    step_t        st_reg;
    logic         vld_reg;
    logic         pend_reg;
    logic         fwd_reg;
    logic [7:0]   fwd_data_reg;
    logic [7:0]   rd_data_reg;

    logic [7:0]   raw;
    logic [7:0]   hv;
    logic [7:0]   byte_val;
    logic [7:0]   out_byte;

    always_comb
    begin
        raw = fwd_reg ? fwd_data_reg : rd_data_reg;
        hv = st_reg.rd_ok ? raw : 8'h00;
        if (st_reg.rev)
        begin
            hv = reverse8(hv);
        end
        byte_val = st_reg.hist ? hv : st_reg.lit;
        out_byte = st_reg.emit ? byte_val : 8'h00;
    end

    assign busy = vld_reg;
    assign m_tvalid = vld_reg;
    assign m_tuser = st_reg.emit;
    assign m_tdata = {6'd0, st_reg.out_length, st_reg.consumed_count, st_reg.error_code,
                      st_reg.done_res, st_reg.need_input, out_byte};

    // The byte of the previous word is written in the cycle after its read, so a read of
    // that same entry in that cycle takes the byte from the forward register.
    always_ff @(posedge clk)
    begin
        if (accept && step.hist)
        begin
            rd_data_reg <= mem[step.rd_addr];
        end
        if (pend_reg && st_reg.wr_en)
        begin
            mem[st_reg.wr_addr] <= byte_val;
        end
        if (accept)
        begin
            st_reg <= step;
            fwd_data_reg <= byte_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            pend_reg <= 1'b0;
            fwd_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= accept && step.emit;
            if (accept)
            begin
                vld_reg <= 1'b1;
                fwd_reg <= pend_reg && st_reg.wr_en && (st_reg.wr_addr == step.rd_addr);
            end
            else if (m_tready)
            begin
                vld_reg <= 1'b0;
            end
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        accept && vld_reg |-> m_tready)
        else $error("word taken over an undelivered result");
    a_pend_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> vld_reg && st_reg.emit)
        else $error("history write without a held result");
    a_fwd_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fwd_reg) |-> vld_reg && $past(pend_reg))
        else $error("forward flag without a preceding write");
endmodule
`default_nettype wire

// ===== sv/lz_block_decompressor_unit.sv =====
`default_nettype none
// Streaming decoder for the block LZ command format. Each input word (tuser = mode,
// tdata = compressed byte) produces exactly one result word in the following cycle, and a new
// word is taken every cycle while the result side keeps up, including long history
// copies: the single 64 KiB history memory is read on acceptance and the decoded byte
// is written back in the next cycle, with a forward path for a copy that reads the byte
// just produced. Entries not yet written since reset read as zero by comparison with the
// write pointer, so no clearing pass is needed. The output limit is written on the cfg
// channel, which is always ready, and should be changed only while the decoder is idle.
module lz_block_decompressor_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [16:0] cfg_data,    // output_limit
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // in_byte
    input  wire logic [1:0]  s_tuser,     // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,     // out_byte, need_input, done_res, error_code,
                                          // consumed_count, out_length, zero fill
    output logic [0:0]       m_tuser      // out_valid
);
    import lzbd_pkg::*;

    step_t step;
    logic  busy;
    logic  accept;

    assign cfg_ready = 1'b1;
    assign s_tready = !busy || m_tready;
    assign accept = s_tvalid && s_tready;

    lzbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .accept   (accept),
        .mode     (s_tuser),
        .in_byte  (s_tdata),
        .step     (step)
    );

    lzbd_hist u_hist (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .step     (step),
        .busy     (busy),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );
endmodule
`default_nettype wire

// ===== tb/lz_block_decompressor_unit_tb.sv =====
`timescale 1ns / 100ps
module lz_block_decompressor_unit_tb;
    import lzbd_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int RANDOM_WORDS = 1000;

    typedef enum logic [2:0] {
        PH_HEADER, PH_EXTLEN, PH_POSHI, PH_POSLO, PH_FILL, PH_EMIT, PH_FINISHED
    } parse_phase_t;

    typedef struct {
        logic        valid;
        logic [7:0]  data;
        logic        need;
        logic        done;
        logic [2:0]  err;
        logic [19:0] cnt;
        logic [16:0] len;
    } decoded_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [16:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [0:0]  m_tuser;

    lz_block_decompressor_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // Decoder state mirrored by the predictor.
    logic [7:0]   hist_mem [0:65535];
    logic [16:0]  wr_pos;
    logic [15:0]  src_pos;
    logic [10:0]  remaining;
    logic [2:0]   cur_cmd;
    parse_phase_t phase;
    logic         toggle;
    logic [7:0]   fill_a;
    logic [7:0]   fill_b;
    logic [19:0]  consumed;
    logic [2:0]   status;
    logic [16:0]  out_limit;

    decoded_word_t expected_decodes[$];
    logic [9:0]    cmd_words[$];
    int errors = 0;
    int stream_words = 0;
    int ignored_words = 0;
    int idle_cycles = 0;
    bit noise_on = 1'b0;
    bit steady = 1'b0;
    bit hold_req = 1'b0;

    function automatic int limit_now();
        return (out_limit < 17'h10000) ? int'(out_limit) : 65536;
    endfunction

    function automatic void tally(input int n);
        consumed = (int'(consumed) + n > int'(COUNT_MAX)) ? COUNT_MAX : consumed + 20'(n);
    endfunction

    function automatic void end_stream(input logic [2:0] st);
        status = st;
        phase = PH_FINISHED;
    endfunction

    function automatic void begin_cmd(input logic [2:0] c, input int len);
        cur_cmd = c;
        remaining = 11'(len);
        toggle = 1'b0;
        if (c == CMD_PAIR && int'(wr_pos) + 2 * len > limit_now())
            end_stream(ERR_LENGTH);
        else if (c >= CMD_COPY)
            phase = PH_POSHI;
        else
            phase = PH_FILL;
    endfunction

    function automatic void feed_byte(input logic [7:0] b);
        int len;
        int pos;
        case (phase)
            PH_HEADER:
            begin
                if (b == HDR_END)
                    end_stream(ST_DONE);
                else if (b[7:5] == CMD_EXTENDED)
                begin
                    cur_cmd = b[4:2];
                    remaining = {1'b0, b[1:0], 8'h00};
                    tally(1);
                    phase = PH_EXTLEN;
                end
                else
                begin
                    len = int'(b[4:0]) + 1;
                    if (int'(wr_pos) + len > limit_now())
                        end_stream(ERR_LENGTH);
                    else
                    begin
                        tally(1);
                        begin_cmd(b[7:5], len);
                    end
                end
            end
            PH_EXTLEN:
            begin
                len = int'(remaining) + int'(b) + 1;
                if (int'(wr_pos) + len > limit_now())
                    end_stream(ERR_LENGTH);
                else
                begin
                    tally(1);
                    begin_cmd(cur_cmd, len);
                end
            end
            PH_POSHI:
            begin
                src_pos = {b, 8'h00};
                phase = PH_POSLO;
            end
            PH_POSLO:
            begin
                pos = int'({src_pos[15:8], b});
                if (pos >= limit_now())
                    end_stream(ERR_POSITION);
                else
                begin
                    tally(2);
                    src_pos = 16'(pos);
                    if ((cur_cmd == CMD_COPY || cur_cmd == CMD_REVCOPY) &&
                        pos + int'(remaining) > limit_now())
                        end_stream(ERR_COPY);
                    else if (cur_cmd == CMD_BACKCOPY && pos + 1 < int'(remaining))
                        end_stream(ERR_UNDERFLOW);
                    else if (cur_cmd == CMD_EXTENDED)
                        end_stream(ERR_RESERVED);
                    else
                        phase = PH_EMIT;
                end
            end
            PH_FILL:
            begin
                if (cur_cmd == CMD_PAIR)
                begin
                    if (!toggle)
                    begin
                        fill_a = b;
                        toggle = 1'b1;
                    end
                    else
                    begin
                        fill_b = b;
                        toggle = 1'b0;
                        tally(2);
                        phase = PH_EMIT;
                    end
                end
                else
                begin
                    fill_a = b;
                    tally(1);
                    phase = PH_EMIT;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] emit_byte();
        logic [7:0] v;
        v = 8'h00;
        case (cur_cmd)
            CMD_LITERAL, CMD_RUN:
            begin
                v = fill_a;
                remaining = remaining - 1'b1;
            end
            CMD_PAIR:
            begin
                v = toggle ? fill_b : fill_a;
                if (toggle)
                    remaining = remaining - 1'b1;
                toggle = ~toggle;
            end
            CMD_INCR:
            begin
                v = fill_a;
                fill_a = fill_a + 1'b1;
                remaining = remaining - 1'b1;
            end
            CMD_COPY, CMD_REVCOPY:
            begin
                v = hist_mem[src_pos];
                if (cur_cmd == CMD_REVCOPY)
                    v = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
                src_pos = src_pos + 1'b1;
                remaining = remaining - 1'b1;
            end
            CMD_BACKCOPY:
            begin
                v = hist_mem[src_pos];
                src_pos = src_pos - 1'b1;
                remaining = remaining - 1'b1;
            end
            default: remaining = '0;
        endcase
        if (!wr_pos[16])
            hist_mem[wr_pos[15:0]] = v;
        wr_pos = wr_pos + 1'b1;
        if (remaining == 0)
            phase = PH_HEADER;
        else if (cur_cmd == CMD_LITERAL)
            phase = PH_FILL;
        return v;
    endfunction

    task automatic decode_step(input logic [1:0] mode, input logic [7:0] b);
        decoded_word_t w;
        w.valid = 1'b0;
        w.data = 8'h00;
        if (phase != PH_FINISHED)
        begin
            if (mode == MODE_FEED && phase != PH_EMIT)
                feed_byte(b);
            else if (mode == MODE_DRAW && phase == PH_EMIT)
            begin
                w.data = emit_byte();
                w.valid = 1'b1;
            end
            else if (mode == MODE_END && phase != PH_EMIT)
            begin
                if (phase == PH_HEADER || (phase == PH_FILL && cur_cmd == CMD_LITERAL))
                    end_stream(ST_DONE);
                else
                    end_stream(ERR_TRUNCATED);
            end
        end
        w.need = (phase != PH_EMIT && phase != PH_FINISHED);
        w.done = (status == ST_DONE);
        w.err = (status == ST_DONE) ? ST_RUNNING : status;
        w.cnt = (consumed == COUNT_MAX) ? COUNT_MAX : consumed + 1'b1;
        w.len = wr_pos;
        expected_decodes.push_back(w);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    // Called just after the clock rises. The valid is only lowered when a gap follows,
    // so that a back-to-back word never sees a low and a high at the same instant.
    task automatic send_word(input logic [1:0] mode, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        decode_step(mode, b);
        stream_words++;
    endtask

    task automatic send_noise();
        logic [1:0] mode;
        if (phase == PH_EMIT)
            case ($urandom_range(0, 2))
                0: mode = MODE_FEED;
                1: mode = MODE_END;
                default: mode = MODE_UNUSED;
            endcase
        else
            mode = $urandom_range(0, 1) ? MODE_DRAW : MODE_UNUSED;
        send_word(mode, 8'($urandom));
        ignored_words++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_decodes.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input int value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= 17'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        out_limit = 17'(value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Feeds the queued compressed bytes, drawing every decoded byte as it comes due.
    task automatic play_words();
        int idx;
        idx = 0;
        while (idx < cmd_words.size() || phase == PH_EMIT)
        begin
            if (noise_on && $urandom_range(0, 15) == 0)
                send_noise();
            else if (phase == PH_EMIT)
                send_word(MODE_DRAW, 8'($urandom));
            else
            begin
                send_word(cmd_words[idx][9:8], cmd_words[idx][7:0]);
                idx++;
            end
        end
    endtask

    task automatic run_command(input logic [2:0] c, input int len, input int pos,
                               input logic [7:0] a, input logic [7:0] b, input bit ext);
        logic [9:0] len1;
        int fills;
        len1 = 10'(len - 1);
        cmd_words.delete();
        if (ext || len > 32)
        begin
            cmd_words.push_back({MODE_FEED, CMD_EXTENDED, c, len1[9:8]});
            cmd_words.push_back({MODE_FEED, len1[7:0]});
        end
        else
            cmd_words.push_back({MODE_FEED, c, len1[4:0]});
        if (c >= CMD_COPY)
        begin
            cmd_words.push_back({MODE_FEED, 8'(pos >> 8)});
            cmd_words.push_back({MODE_FEED, 8'(pos)});
        end
        fills = (c == CMD_LITERAL) ? len : (c == CMD_PAIR) ? 2 : (c < CMD_COPY) ? 1 : 0;
        for (int i = 0; i < fills; i++)
            cmd_words.push_back({MODE_FEED, (i == 0) ? a : (i == 1) ? b : 8'($urandom)});
        play_words();
    endtask

    task automatic random_command();
        logic [2:0] c;
        int len;
        int space;
        int hi;
        int pos;
        c = $urandom_range(0, 6);
        if ($urandom_range(0, 99) < 3)
            len = $urandom_range(33, 1024);
        else
            len = $urandom_range(1, 32);
        space = limit_now() - int'(wr_pos);
        while (len > 1 && ((c == CMD_PAIR) ? 2 * len : len) > space)
            len = len / 2;
        pos = 0;
        if (c == CMD_COPY || c == CMD_REVCOPY)
        begin
            hi = limit_now() - len;
            if ($urandom_range(0, 3) != 0 && wr_pos > 0 && int'(wr_pos) - 1 < hi)
                hi = int'(wr_pos) - 1;
            pos = $urandom_range(0, hi);
        end
        else if (c == CMD_BACKCOPY)
        begin
            hi = limit_now() - 1;
            if ($urandom_range(0, 3) != 0 && int'(wr_pos) - 1 >= len - 1)
                hi = int'(wr_pos) - 1;
            pos = $urandom_range(len - 1, hi);
        end
        run_command(c, len, pos, 8'($urandom), 8'($urandom), $urandom_range(0, 4) == 0);
    endtask

    task automatic test_limit_extremes();
        write_limit(1);
        run_command(CMD_LITERAL, 1, 0, 8'hA5, 8'h00, 1'b0);
        write_limit(int'(LIMIT_RESET));
    endtask

    task automatic test_each_command();
        run_command(CMD_LITERAL, 2, 0, 8'h00, 8'hFF, 1'b0);
        run_command(CMD_RUN, 32, 0, 8'hFF, 8'h00, 1'b0);
        run_command(CMD_PAIR, 3, 0, 8'h55, 8'hAA, 1'b0);
        run_command(CMD_INCR, 4, 0, 8'hFE, 8'h00, 1'b0);
        run_command(CMD_COPY, 6, 0, 8'h00, 8'h00, 1'b0);
        run_command(CMD_REVCOPY, 6, 1, 8'h00, 8'h00, 1'b0);
        run_command(CMD_BACKCOPY, 5, int'(wr_pos) - 1, 8'h00, 8'h00, 1'b1);
        // Reads entries never written in this stream, which hold zero since reset.
        run_command(CMD_COPY, 3, 60000, 8'h00, 8'h00, 1'b0);
    endtask

    task automatic test_output_backpressure();
        hold_req = 1'b1;
        run_command(CMD_RUN, 32, 0, 8'h3C, 8'h00, 1'b0);
        drain();
    endtask

    task automatic test_random_streams();
        noise_on = 1'b1;
        for (int p = 0; p < 4; p++)
        begin
            write_limit((p == 0) ? 65536 : $urandom_range(int'(wr_pos) + 4000, 65536));
            steady = (p == 2);
            while (stream_words - ignored_words < (p + 1) * (RANDOM_WORDS / 4) + 120)
                random_command();
        end
        steady = 1'b0;
        noise_on = 1'b0;
    endtask

    task automatic test_stream_end();
        cmd_words.delete();
        case ($urandom_range(0, 8))
            0:
            begin
                write_limit(int'(wr_pos));
                cmd_words.push_back({MODE_FEED, 8'h00});
            end
            1:
            begin
                write_limit(int'(wr_pos) + 10);
                cmd_words.push_back({MODE_FEED, CMD_COPY, 5'd0});
                cmd_words.push_back({MODE_FEED, 8'hFF});
                cmd_words.push_back({MODE_FEED, 8'hFF});
            end
            2:
            begin
                cmd_words.push_back({MODE_FEED, CMD_COPY, 5'd1});
                cmd_words.push_back({MODE_FEED, 8'((limit_now() - 1) >> 8)});
                cmd_words.push_back({MODE_FEED, 8'(limit_now() - 1)});
            end
            3:
            begin
                cmd_words.push_back({MODE_FEED, CMD_BACKCOPY, 5'd4});
                cmd_words.push_back({MODE_FEED, 8'h00});
                cmd_words.push_back({MODE_FEED, 8'h00});
            end
            4:
            begin
                cmd_words.push_back({MODE_FEED, CMD_EXTENDED, CMD_EXTENDED, 2'd0});
                cmd_words.push_back({MODE_FEED, 8'h00});
                cmd_words.push_back({MODE_FEED, 8'h00});
                cmd_words.push_back({MODE_FEED, 8'h00});
            end
            5: cmd_words.push_back({MODE_FEED, HDR_END});
            6: cmd_words.push_back({MODE_END, 8'h00});
            7:
            begin
                cmd_words.push_back({MODE_FEED, CMD_LITERAL, 5'd2});
                cmd_words.push_back({MODE_FEED, 8'($urandom)});
                cmd_words.push_back({MODE_END, 8'h00});
            end
            default:
            begin
                cmd_words.push_back({MODE_FEED, CMD_RUN, 5'd0});
                cmd_words.push_back({MODE_END, 8'h00});
            end
        endcase
        // Once ended, every further word is ignored and the status holds.
        for (int i = 0; i < 8; i++)
            cmd_words.push_back(10'($urandom));
        play_words();
        drain();
    endtask

    initial
    begin
        for (int i = 0; i < 65536; i++)
            hist_mem[i] = 8'h00;
        wr_pos = '0;
        src_pos = '0;
        remaining = '0;
        cur_cmd = CMD_LITERAL;
        phase = PH_HEADER;
        toggle = 1'b0;
        fill_a = '0;
        fill_b = '0;
        consumed = '0;
        status = ST_RUNNING;
        out_limit = LIMIT_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_limit_extremes();
        test_each_command();
        test_output_backpressure();
        test_random_streams();
        test_stream_end();
        repeat (10) @(posedge clk);
        if (expected_decodes.size() > 0)
            report_mismatch("words never produced", expected_decodes.size(), 0);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Result side: random stalls, or one long hold counted here while the sender keeps going.
    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!steady && $urandom_range(0, 9) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        decoded_word_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_decodes.size() == 0)
                report_mismatch("unexpected word", m_tdata[31:0], 0);
            else
            begin
                w = expected_decodes.pop_front();
                if (m_tuser[0] !== w.valid)
                    report_mismatch("out_valid", m_tuser[0], w.valid);
                if (m_tdata[7:0] !== w.data)
                    report_mismatch("out_byte", m_tdata[7:0], w.data);
                if (m_tdata[8] !== w.need)
                    report_mismatch("need_input", m_tdata[8], w.need);
                if (m_tdata[9] !== w.done)
                    report_mismatch("done_res", m_tdata[9], w.done);
                if (m_tdata[12:10] !== w.err)
                    report_mismatch("error_code", m_tdata[12:10], w.err);
                if (m_tdata[32:13] !== w.cnt)
                    report_mismatch("consumed_count", m_tdata[32:13], w.cnt);
                if (m_tdata[49:33] !== w.len)
                    report_mismatch("out_length", m_tdata[49:33], w.len);
                if (m_tdata[55:50] !== 6'd0)
                    report_mismatch("fill bits", m_tdata[55:50], 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
